[hdl/mail_recipient_list_checker_assert.svh]
// Assertion macros used by the recipient list checker state logic.
`ifndef MAIL_RECIPIENT_LIST_CHECKER_ASSERT_SVH
`define MAIL_RECIPIENT_LIST_CHECKER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define MRLC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset.
`define MRLC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MRLC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRLC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/mrlc_pkg.sv]
// Shared types, codes and helpers for the recipient list checker.
package mrlc_pkg;

  // Default limits
  localparam int unsigned MAX_RECIPIENTS_DEF = 16;
  localparam int unsigned ADDRESS_BYTES_DEF  = 256;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_FIELD_BYTE  = 2'd0,
    OP_END_FIELD   = 2'd1,
    OP_SUBJ_BYTE   = 2'd2,
    OP_END_LETTER  = 2'd3
  } op_t;

  // Letter status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOBODY     = 3'd1,
    ST_CTRL_FIELD = 3'd2,
    ST_TOO_MANY   = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_NOT_ADDR   = 3'd5,
    ST_CTRL_SUBJ  = 3'd6
  } status_t;

  // Characters of interest
  localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_DEL        = 8'h7F;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;

  // One input item
  typedef struct packed {
    op_t        opcode;
    logic [7:0] data_byte;
  } item_t;

  // One result item
  typedef struct packed {
    status_t    status;
    logic [4:0] recipient_count;
    logic       letter_done;
  } result_t;

  // Control byte: below space, or DEL
  function automatic logic is_control(input logic [7:0] b);
    return (b < CH_CTRL_LIMIT) || (b == CH_DEL);
  endfunction

endpackage

[hdl/mrlc_state.sv]
// Letter state registers and the per-item update logic.
`include "mail_recipient_list_checker_assert.svh"
module mrlc_state #(
  parameter int unsigned MAX_RECIPIENTS = mrlc_pkg::MAX_RECIPIENTS_DEF,
  parameter int unsigned ADDRESS_BYTES  = mrlc_pkg::ADDRESS_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  mrlc_pkg::item_t   item,
  output mrlc_pkg::result_t result
);

  localparam int unsigned LEN_W = $clog2(ADDRESS_BYTES + 1);
  localparam int unsigned CNT_W = $clog2(MAX_RECIPIENTS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDRESS_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECIPIENTS);

  logic [LEN_W-1:0]  entry_length_r, entry_length_nxt;
  logic [LEN_W-1:0]  pending_spaces_r, pending_spaces_nxt;
  logic [1:0]        at_sign_count_r, at_sign_count_nxt;
  logic              first_is_at_r, first_is_at_nxt;
  logic              last_is_at_r, last_is_at_nxt;
  logic              forbidden_seen_r, forbidden_seen_nxt;
  logic              field_has_control_r, field_has_control_nxt;
  mrlc_pkg::status_t field_first_error_r, field_first_error_nxt;
  mrlc_pkg::status_t letter_status_r, letter_status_nxt;
  logic [CNT_W-1:0]  accepted_count_r, accepted_count_nxt;
  logic              subject_has_control_r, subject_has_control_nxt;

  logic              entry_open;
  logic              byte_ctrl;
  logic              byte_at;
  logic [LEN_W:0]    grown_sum;
  logic [LEN_W-1:0]  grown_length;
  mrlc_pkg::status_t entry_err;
  mrlc_pkg::status_t closed_ffe;
  logic [CNT_W-1:0]  closed_cnt;
  mrlc_pkg::status_t end_status;
  logic [CNT_W-1:0]  end_cnt;
  mrlc_pkg::status_t letter_end_status;
  logic              clear_entry;

  assign entry_open = (entry_length_r != '0);
  assign byte_ctrl  = mrlc_pkg::is_control(item.data_byte);
  assign byte_at    = (item.data_byte == mrlc_pkg::CH_AT);

  // Trimmed length after a non-space byte, held spaces become inner ones
  assign grown_sum    = {1'b0, entry_length_r} + {1'b0, pending_spaces_r} + (LEN_W + 1)'(1);
  assign grown_length = !entry_open ? LEN_W'(1) :
                        (grown_sum > {1'b0, LEN_MAX}) ? LEN_MAX : grown_sum[LEN_W-1:0];

  // Verdict on the open entry, in priority order
  always_comb begin
    if (accepted_count_r >= CNT_MAX) begin
      entry_err = mrlc_pkg::ST_TOO_MANY;
    end else if (entry_length_r >= LEN_MAX) begin
      entry_err = mrlc_pkg::ST_TOO_LONG;
    end else if (at_sign_count_r != 2'd1 || first_is_at_r || last_is_at_r ||
                 forbidden_seen_r) begin
      entry_err = mrlc_pkg::ST_NOT_ADDR;
    end else begin
      entry_err = mrlc_pkg::ST_OK;
    end
  end

  // Close the entry: record its error or count it
  always_comb begin
    closed_ffe = field_first_error_r;
    closed_cnt = accepted_count_r;
    if (field_first_error_r == mrlc_pkg::ST_OK && entry_open) begin
      if (entry_err != mrlc_pkg::ST_OK) begin
        closed_ffe = entry_err;
      end else begin
        closed_cnt = accepted_count_r + CNT_W'(1);
      end
    end
  end

  // Close the field and fold its outcome into the letter status
  always_comb begin
    if (letter_status_r == mrlc_pkg::ST_OK) begin
      end_status = field_has_control_r ? mrlc_pkg::ST_CTRL_FIELD : closed_ffe;
      end_cnt    = closed_cnt;
    end else begin
      end_status = letter_status_r;
      end_cnt    = accepted_count_r;
    end
    if (end_status != mrlc_pkg::ST_OK) begin
      letter_end_status = end_status;
    end else if (end_cnt == '0) begin
      letter_end_status = mrlc_pkg::ST_NOBODY;
    end else if (subject_has_control_r) begin
      letter_end_status = mrlc_pkg::ST_CTRL_SUBJ;
    end else begin
      letter_end_status = mrlc_pkg::ST_OK;
    end
  end

  // Next state for the item in hand
  always_comb begin
    entry_length_nxt        = entry_length_r;
    pending_spaces_nxt      = pending_spaces_r;
    at_sign_count_nxt       = at_sign_count_r;
    first_is_at_nxt         = first_is_at_r;
    last_is_at_nxt          = last_is_at_r;
    forbidden_seen_nxt      = forbidden_seen_r;
    field_has_control_nxt   = field_has_control_r;
    field_first_error_nxt   = field_first_error_r;
    letter_status_nxt       = letter_status_r;
    accepted_count_nxt      = accepted_count_r;
    subject_has_control_nxt = subject_has_control_r;
    clear_entry             = 1'b0;
    result.status           = letter_status_r;
    result.recipient_count  = 5'(accepted_count_r);
    result.letter_done      = 1'b0;

    case (item.opcode)
      mrlc_pkg::OP_FIELD_BYTE: begin
        if (letter_status_r == mrlc_pkg::ST_OK) begin
          if (byte_ctrl) begin
            field_has_control_nxt = 1'b1;
          end else if (field_first_error_r == mrlc_pkg::ST_OK) begin
            if (item.data_byte == mrlc_pkg::CH_COMMA) begin
              field_first_error_nxt = closed_ffe;
              accepted_count_nxt    = closed_cnt;
              clear_entry           = 1'b1;
            end else if (item.data_byte == mrlc_pkg::CH_SPACE) begin
              if (entry_open && pending_spaces_r < LEN_MAX) begin
                pending_spaces_nxt = pending_spaces_r + LEN_W'(1);
              end
            end else begin
              if (!entry_open) begin
                first_is_at_nxt = byte_at;
              end
              entry_length_nxt   = grown_length;
              forbidden_seen_nxt = forbidden_seen_r ||
                                   (entry_open && pending_spaces_r != '0) ||
                                   item.data_byte == mrlc_pkg::CH_LT ||
                                   item.data_byte == mrlc_pkg::CH_GT;
              pending_spaces_nxt = '0;
              last_is_at_nxt     = byte_at;
              if (byte_at && at_sign_count_r != 2'd2) begin
                at_sign_count_nxt = at_sign_count_r + 2'd1;
              end
            end
          end
        end
        result.recipient_count = 5'(accepted_count_nxt);
      end
      mrlc_pkg::OP_END_FIELD: begin
        letter_status_nxt      = end_status;
        accepted_count_nxt     = end_cnt;
        field_has_control_nxt  = 1'b0;
        field_first_error_nxt  = mrlc_pkg::ST_OK;
        clear_entry            = 1'b1;
        result.status          = end_status;
        result.recipient_count = 5'(end_cnt);
      end
      mrlc_pkg::OP_SUBJ_BYTE: begin
        if (letter_status_r == mrlc_pkg::ST_OK && byte_ctrl) begin
          subject_has_control_nxt = 1'b1;
        end
      end
      mrlc_pkg::OP_END_LETTER: begin
        // Report, then clear everything for the next letter
        letter_status_nxt       = mrlc_pkg::ST_OK;
        accepted_count_nxt      = '0;
        subject_has_control_nxt = 1'b0;
        field_has_control_nxt   = 1'b0;
        field_first_error_nxt   = mrlc_pkg::ST_OK;
        clear_entry             = 1'b1;
        result.status           = letter_end_status;
        result.recipient_count  = 5'(end_cnt);
        result.letter_done      = 1'b1;
      end
      default: begin
        clear_entry = 1'b0;
      end
    endcase

    if (clear_entry) begin
      entry_length_nxt   = '0;
      pending_spaces_nxt = '0;
      at_sign_count_nxt  = 2'd0;
      first_is_at_nxt    = 1'b0;
      last_is_at_nxt     = 1'b0;
      forbidden_seen_nxt = 1'b0;
    end
  end

  // Hold state, advance on each stepped item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_length_r        <= '0;
      pending_spaces_r      <= '0;
      at_sign_count_r       <= 2'd0;
      first_is_at_r         <= 1'b0;
      last_is_at_r          <= 1'b0;
      forbidden_seen_r      <= 1'b0;
      field_has_control_r   <= 1'b0;
      field_first_error_r   <= mrlc_pkg::ST_OK;
      letter_status_r       <= mrlc_pkg::ST_OK;
      accepted_count_r      <= '0;
      subject_has_control_r <= 1'b0;
    end else if (step) begin
      entry_length_r        <= entry_length_nxt;
      pending_spaces_r      <= pending_spaces_nxt;
      at_sign_count_r       <= at_sign_count_nxt;
      first_is_at_r         <= first_is_at_nxt;
      last_is_at_r          <= last_is_at_nxt;
      forbidden_seen_r      <= forbidden_seen_nxt;
      field_has_control_r   <= field_has_control_nxt;
      field_first_error_r   <= field_first_error_nxt;
      letter_status_r       <= letter_status_nxt;
      accepted_count_r      <= accepted_count_nxt;
      subject_has_control_r <= subject_has_control_nxt;
    end
  end

  `MRLC_ASSERT(a_count_in_range, clk, rst_n, accepted_count_r <= CNT_MAX, "recipient count above limit")
  `MRLC_ASSERT(a_length_in_range, clk, rst_n, entry_length_r <= LEN_MAX && pending_spaces_r <= LEN_MAX, "entry length above limit")
  `MRLC_ASSERT_NEVER(a_no_spaces_on_empty, clk, rst_n, entry_length_r == '0 && pending_spaces_r != '0, "spaces held with no entry")
  `MRLC_ASSERT(a_letter_clears, clk, rst_n, step && item.opcode == mrlc_pkg::OP_END_LETTER |=> accepted_count_r == '0 && letter_status_r == mrlc_pkg::ST_OK, "state not cleared after letter")
  `MRLC_ASSERT(a_status_sticky, clk, rst_n, letter_status_r != mrlc_pkg::ST_OK && !(step && item.opcode == mrlc_pkg::OP_END_LETTER) |=> letter_status_r == $past(letter_status_r), "letter status changed before letter end")

endmodule

[hdl/mail_recipient_list_checker.sv]
// Top level of the recipient list checker: input register, state update, result register.
//
// One item is accepted per clock cycle while results are taken. On its way to the output, the
// item is captured in an input register, the letter state is updated by a single level of
// flag and counter logic, and the result is captured in an output register. Throughput is set
// only by the result side: while the output register holds a result that is not taken, the
// input register fills and then in_tready drops. The letter status is sticky until the
// end-of-letter item, whose result carries tlast; all state then clears for the next letter.
module mail_recipient_list_checker #(
  parameter int unsigned MAX_RECIPIENTS = mrlc_pkg::MAX_RECIPIENTS_DEF,
  parameter int unsigned ADDRESS_BYTES  = mrlc_pkg::ADDRESS_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] status, [7:3] recipient_count
  output logic       out_tlast   // letter_done
);

  logic              in_valid_r, in_valid_nxt;
  mrlc_pkg::item_t   in_item_r;
  logic              out_valid_r, out_valid_nxt;
  mrlc_pkg::result_t out_res_r;
  mrlc_pkg::result_t step_res;
  logic              out_free;
  logic              step;
  logic              in_xfer;

  // Move the held item on when the result slot is free or being emptied
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Update the letter state
  mrlc_state #(
    .MAX_RECIPIENTS (MAX_RECIPIENTS),
    .ADDRESS_BYTES  (ADDRESS_BYTES)
  ) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (step_res)
  );

  // Hold handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.opcode    <= mrlc_pkg::op_t'(in_tuser);
      in_item_r.data_byte <= in_tdata;
    end
    if (step) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.recipient_count, out_res_r.status};
  assign out_tlast  = out_res_r.letter_done;

endmodule
